/* hdl/lsq_pkg.sv */
package lsq_pkg;

    // Width of the centroid numerator: 16*sum(pos) - offset*count
    localparam int ACC_W = 17;
    localparam int ERR_W = 13;
    localparam int CNT_W = 4;
    localparam int LOST_W = 16;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_BLACK_HIGH = 3'd0;
    localparam logic [2:0] CFG_REVERSE    = 3'd1;
    localparam logic [2:0] CFG_MAJORITY   = 3'd2;
    localparam logic [2:0] CFG_MIN_COUNT  = 3'd3;
    localparam logic [2:0] CFG_MIN_RUN    = 3'd4;
    localparam logic [2:0] CFG_CONFIRM    = 3'd5;
    localparam logic [2:0] CFG_POSITIONS  = 3'd6;
    localparam logic [2:0] CFG_CENTER     = 3'd7;

    // Center channels that a marker must cover
    localparam logic [7:0] CENTER_BITS = 8'h18;
    localparam logic [LOST_W-1:0] LOST_MAX = 16'hFFFF;
    localparam logic signed [ERR_W-1:0] ERR_MAX = 13'sd4095;
    localparam logic signed [ERR_W-1:0] ERR_MIN = -13'sd4096;

    // Totals collected by the serial channel scan
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic [CNT_W-1:0]        longest;
        logic signed [ACC_W-1:0] sum;
    } scan_res_t;

endpackage

/* hdl/lsq_scan.sv */
module lsq_scan
    import lsq_pkg::*;
#(
    parameter int SENSOR_COUNT = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [7:0]       mask,
    input  logic [63:0]      positions,
    input  logic [11:0]      center_offset,
    output logic             done,
    output scan_res_t        res
);

    localparam int STEP_W = $clog2(SENSOR_COUNT);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SENSOR_COUNT - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [7:0]              mask_reg;
    logic [63:0]             pos_reg;
    logic [11:0]             offset_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        run_reg;
    logic [CNT_W-1:0]        longest_reg;
    logic signed [ACC_W-1:0] sum_reg;

    logic [CNT_W-1:0]        run_next;
    logic signed [ACC_W-1:0] term;

    // Position of this channel in sixteenths, less the center offset
    always_comb
    begin
        run_next = run_reg + CNT_W'(1);
        term = $signed({{5{pos_reg[7]}}, pos_reg[7:0], 4'b0000})
             - $signed({{5{offset_reg[11]}}, offset_reg});
    end

    // Walk the channels one per cycle, channel 0 first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the mask and position bytes, accumulate totals
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mask_reg    <= mask;
            pos_reg     <= positions;
            offset_reg  <= center_offset;
            count_reg   <= '0;
            run_reg     <= '0;
            longest_reg <= '0;
            sum_reg     <= '0;
        end
        else if (busy_reg)
        begin
            mask_reg <= {mask_reg[6:0], 1'b0};
            pos_reg  <= {8'h00, pos_reg[63:8]};
            if (mask_reg[7])
            begin
                count_reg <= count_reg + CNT_W'(1);
                run_reg   <= run_next;
                sum_reg   <= sum_reg + term;
                if (run_next > longest_reg)
                begin
                    longest_reg <= run_next;
                end
            end
            else
            begin
                run_reg <= '0;
            end
        end
    end

    assign done        = done_reg;
    assign res.count   = count_reg;
    assign res.longest = longest_reg;
    assign res.sum     = sum_reg;

endmodule

/* hdl/lsq_div.sv */
module lsq_div
    import lsq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] num,
    input  logic [CNT_W-1:0]        den,
    output logic                    done,
    output logic signed [ERR_W-1:0] quot
);

    localparam int MAG_W = ACC_W - 1;

    logic               busy_reg;
    logic               done_reg;
    logic [3:0]         step_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   den_reg;
    logic               neg_reg;

    logic [ACC_W-1:0]        num_abs;
    logic [CNT_W-1:0]        trial;
    logic                    fits;
    logic signed [ACC_W-1:0] qv;

    // Restoring step: one quotient bit per cycle
    always_comb
    begin
        num_abs = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
        trial   = {rem_reg[CNT_W-2:0], mag_reg[MAG_W-1]};
        fits    = trial >= den_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= num_abs[MAG_W-1:0];
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[ACC_W-1];
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[MAG_W-2:0], fits};
            rem_reg <= fits ? trial - den_reg : trial;
        end
    end

    // Restore the sign (truncation toward zero) and saturate
    always_comb
    begin
        qv = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        if (qv > ACC_W'(ERR_MAX))
        begin
            quot = ERR_MAX;
        end
        else if (qv < ACC_W'(ERR_MIN))
        begin
            quot = ERR_MIN;
        end
        else
        begin
            quot = qv[ERR_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

/* hdl/line_sensor_qualifier_core.sv */
// Line sensor qualifier.
// s_tdata carries one raw scan of the sensors (bit 7 is channel 0); a scan is
// taken on a transfer with s_tvalid and s_tready high. The cfg channel writes
// one register per transfer (cfg_index, cfg_data); cfg_ready is always high
// and registers should only change while no scan is in progress.
// m_tdata carries one result per scan: filtered mask, active count, marker
// flag, line-valid flag, line error and lost count.
// Timing: the mask is walked one channel per cycle through a shift register.
// When the line is valid (some channel active, no confirmed marker) the
// centroid is divided by the active count in a bit-serial divider. The
// result is then loaded into the output register, and s_tready returns in
// the same cycle that m_tvalid rises for that result.
// A result waiting in the output register does not block the next scan; the
// next result waits until the previous one is transferred.
// Reset restores register defaults, clears the scan history, the marker
// counters, the lost count and the held line error, and drops m_tvalid.
module line_sensor_qualifier_core
    import lsq_pkg::*;
#(
    parameter int SENSOR_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] raw_levels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] sensor_mask, [11:8] active_count,
                                   // [12] marker_detected, [13] line_valid,
                                   // [26:14] line_error, [42:27] lost_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;

    localparam logic [7:0] USED_MASK = 8'(8'hFF << (8 - SENSOR_COUNT));

    // Configuration registers
    logic        black_high_reg;
    logic        reverse_reg;
    logic        majority_reg;
    logic [3:0]  min_count_reg;
    logic [3:0]  min_run_reg;
    logic [7:0]  confirm_reg;
    logic [63:0] positions_reg;
    logic [11:0] center_reg;

    // Block state
    logic [2:0]              state_reg;
    logic [7:0]              hist0_reg;
    logic [7:0]              hist1_reg;
    logic                    filled_reg;
    logic [7:0]              hits_reg;
    logic [7:0]              clears_reg;
    logic [LOST_W-1:0]       lost_reg;
    logic signed [ERR_W-1:0] last_good_reg;

    // Per-scan results
    logic [7:0]              mask_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    det_reg;
    logic                    valid_reg;
    logic signed [ERR_W-1:0] err_reg;

    logic        out_valid_reg;
    logic [47:0] out_data_reg;

    logic              accept;
    logic [7:0]        pol;
    logic [7:0]        act;
    logic [7:0]        h0_next;
    logic [7:0]        h1_next;
    logic [7:0]        h2_next;
    logic [7:0]        mask_next;
    logic              scan_done;
    scan_res_t         scan_res;
    logic              div_start;
    logic              div_done;
    logic signed [ERR_W-1:0] div_quot;
    logic [7:0]        conf;
    logic              sig;
    logic [7:0]        clr_inc;
    logic [7:0]        hits_next;
    logic [7:0]        clears_next;
    logic              det_next;
    logic              valid_next;
    logic [LOST_W-1:0] lost_next;
    logic              out_load;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    // Polarity, unused channels, optional mirror, history and majority
    always_comb
    begin
        pol = (black_high_reg ? s_tdata : ~s_tdata) & USED_MASK;
        act = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            act[8 - SENSOR_COUNT + i] = pol[7 - i];
        end
        if (!reverse_reg)
        begin
            act = pol;
        end
        h0_next = act;
        h1_next = filled_reg ? hist0_reg : act;
        h2_next = filled_reg ? hist1_reg : act;
        if (majority_reg)
        begin
            mask_next = (h0_next & h1_next) | (h0_next & h2_next) | (h1_next & h2_next);
        end
        else
        begin
            mask_next = act;
        end
    end

    // Marker hysteresis and lost counter, evaluated when the scan finishes
    always_comb
    begin
        conf = (confirm_reg == 8'd0) ? 8'd1 : confirm_reg;
        sig  = (scan_res.count >= min_count_reg) &&
               ((mask_reg & CENTER_BITS) == CENTER_BITS) &&
               (scan_res.longest >= min_run_reg);
        clr_inc = (clears_reg < conf) ? clears_reg + 8'd1 : clears_reg;
        if (sig)
        begin
            clears_next = 8'd0;
            hits_next   = (hits_reg < conf) ? hits_reg + 8'd1 : hits_reg;
        end
        else
        begin
            clears_next = clr_inc;
            hits_next   = (clr_inc >= conf) ? 8'd0 : hits_reg;
        end
        det_next   = hits_next >= conf;
        valid_next = (scan_res.count != '0) && !det_next;
        if (scan_res.count == '0)
        begin
            lost_next = (lost_reg == LOST_MAX) ? lost_reg : lost_reg + LOST_W'(1);
        end
        else
        begin
            lost_next = '0;
        end
    end

    assign div_start = (state_reg == ST_SCAN) && scan_done && valid_next;

    lsq_scan #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept),
        .mask          (mask_next),
        .positions     (positions_reg),
        .center_offset (center_reg),
        .done          (scan_done),
        .res           (scan_res)
    );

    lsq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (scan_res.sum),
        .den   (scan_res.count),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_high_reg <= 1'b1;
            reverse_reg    <= 1'b0;
            majority_reg   <= 1'b1;
            min_count_reg  <= 4'd5;
            min_run_reg    <= 4'd4;
            confirm_reg    <= 8'd3;
            positions_reg  <= '0;
            center_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BLACK_HIGH: black_high_reg <= cfg_data[0];
                CFG_REVERSE:    reverse_reg    <= cfg_data[0];
                CFG_MAJORITY:   majority_reg   <= cfg_data[0];
                CFG_MIN_COUNT:  min_count_reg  <= cfg_data[3:0];
                CFG_MIN_RUN:    min_run_reg    <= cfg_data[3:0];
                CFG_CONFIRM:    confirm_reg    <= cfg_data[7:0];
                CFG_POSITIONS:  positions_reg  <= cfg_data;
                CFG_CENTER:     center_reg     <= cfg_data[11:0];
                default:        ;
            endcase
        end
    end

    // Sequence one scan: accept, walk channels, divide if the line is valid, hand off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hist0_reg     <= '0;
            hist1_reg     <= '0;
            filled_reg    <= 1'b0;
            hits_reg      <= '0;
            clears_reg    <= '0;
            lost_reg      <= '0;
            last_good_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        hist0_reg  <= h0_next;
                        hist1_reg  <= h1_next;
                        filled_reg <= 1'b1;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_done)
                    begin
                        hits_reg   <= hits_next;
                        clears_reg <= clears_next;
                        lost_reg   <= lost_next;
                        state_reg  <= valid_next ? ST_DIV : ST_FIN;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        last_good_reg <= div_quot;
                        state_reg     <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Per-scan payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mask_reg <= mask_next;
        end
        if ((state_reg == ST_SCAN) && scan_done)
        begin
            count_reg <= scan_res.count;
            det_reg   <= det_next;
            valid_reg <= valid_next;
            err_reg   <= last_good_reg;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            err_reg <= div_quot;
        end
        if (out_load)
        begin
            out_data_reg <= {5'b00000, lost_reg, err_reg, valid_reg, det_reg,
                             count_reg, mask_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_marker_holds_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[12] && m_tdata[13]))
        else $error("line_valid set with a confirmed marker");

    a_valid_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[13]) |-> (m_tdata[11:8] != 4'd0))
        else $error("line_valid set with no active sensor");

    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($countones(m_tdata[7:0]) == int'(m_tdata[11:8])))
        else $error("active_count disagrees with sensor_mask");

    a_lost_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[11:8] != 4'd0)) |-> (m_tdata[42:27] == 16'd0))
        else $error("lost_count nonzero while a sensor is active");

    a_divider_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIV))
        else $error("divider started outside the divide step");
`endif

endmodule
